FILE: design/ride_trip_statistics_top_macros.svh
// Assertion macros for the ride trip statistics top module
`ifndef RIDE_TRIP_STATISTICS_TOP_MACROS_SVH
`define RIDE_TRIP_STATISTICS_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define RTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define RTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/rts_pkg.sv
// Shared constants and types of the ride trip statistics block
package rts_pkg;

   localparam int NUM_W = 48;
   localparam int DEN_W = 32;
   localparam int CNT_W = 6;

   localparam logic [2:0] FN_UPDATE = 3'd0;
   localparam logic [2:0] FN_START  = 3'd1;
   localparam logic [2:0] FN_PAUSE  = 3'd2;
   localparam logic [2:0] FN_RESUME = 3'd3;
   localparam logic [2:0] FN_FINISH = 3'd4;
   localparam logic [2:0] FN_NEW    = 3'd5;

   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_RIDING   = 2'd1;
   localparam logic [1:0] MODE_PAUSED   = 2'd2;
   localparam logic [1:0] MODE_FINISHED = 2'd3;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_CIRC      = 2'd1;
   localparam logic [1:0] REG_PPR       = 2'd2;

   localparam logic [15:0] THRESHOLD_RESET = 16'd300;
   localparam logic [15:0] CIRC_RESET      = 16'd2194;
   localparam logic [7:0]  PPR_RESET       = 8'd1;

   localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: design/rts_divider.sv
// Shared restoring divider, one quotient bit per cycle
module rts_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rts_pkg::NUM_W-1:0]       dividend,
   input  logic [rts_pkg::DEN_W-1:0]       divisor,
   output logic [rts_pkg::NUM_W-1:0]       quotient,
   output rts_pkg::div_stat_type           stat
);

   logic [rts_pkg::NUM_W-1:0] dvd_ff, dvd_in;
   logic [rts_pkg::DEN_W-1:0] dvs_ff, dvs_in;
   logic [rts_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [rts_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [rts_pkg::DEN_W:0]   trial;
   logic [rts_pkg::DEN_W:0]   diff;
   logic                      fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[rts_pkg::NUM_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = rts_pkg::CNT_W'(rts_pkg::NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in  = fits ? diff[rts_pkg::DEN_W-1:0] : trial[rts_pkg::DEN_W-1:0];
         dvd_in  = {dvd_ff[rts_pkg::NUM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == rts_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = dvd_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: design/ride_trip_statistics_top.sv
// Bike trip computer: ride state, time, distance and speed statistics
//
// Usage:
//  - Input channel req_*: one transaction carries a command (req_tuser) and a
//    timestamp, speed and absolute wheel pulse count (req_tdata). Commands:
//    update, start, pause, resume, finish, new ride; other codes change nothing.
//  - Result channel rsp_*: exactly one transaction per command, holding the
//    statistics after the command took effect.
//  - Configuration port csr_*: stop threshold (0x0), wheel circumference
//    (0x4), pulses per revolution (0x8). Write only while the block is idle.
//  - Processing: the PREP and APPLY states prepare and apply the step; then
//    the shared 48-step divider runs three times, for distance and each
//    average. A zero time base skips its divide.
//  - Flow: req_tready is high only while no command is being worked on, so a
//    new command is taken only after the last one has left the state machine.
//  - A finished result sits in the output register; the next command is
//    taken meanwhile, and its result waits until the receiver takes the old.
//  - Reset clears the ride state, all statistics and the registers to their
//    defaults (300, 2194, 1); the first update after reset only loads time and pulse count.
`include "ride_trip_statistics_top_macros.svh"

module ride_trip_statistics_top (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: now_ms[31:0], speed[47:32], absolute_pulses[79:48]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,
   // req_tuser: func[2:0]
   input  logic [2:0]   req_tuser,
   // rsp_tdata: ride_state[1:0], is_moving[2], elapsed_ms[34:3],
   // recording_ms[66:35], moving_ms[98:67], pause_ms[130:99],
   // stopped_ms[162:131], distance_mm[194:163], pulse_total[226:195],
   // max_speed[242:227], avg_moving_speed[258:243],
   // avg_recording_speed[274:259], zero fill[279:275]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [279:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_PREP   = 10'b00_0000_0010,
      ST_APPLY  = 10'b00_0000_0100,
      ST_DSTART = 10'b00_0000_1000,
      ST_DWAIT  = 10'b00_0001_0000,
      ST_MSTART = 10'b00_0010_0000,
      ST_MWAIT  = 10'b00_0100_0000,
      ST_RSTART = 10'b00_1000_0000,
      ST_RWAIT  = 10'b01_0000_0000,
      ST_SEND   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] thr_ff, thr_in;
   logic [15:0] circ_ff, circ_in;
   logic [7:0]  ppr_ff, ppr_in;

   // captured command
   logic [2:0]  func_ff, func_in;
   logic [31:0] now_ff, now_in;
   logic [15:0] speed_ff, speed_in;
   logic [31:0] abs_ff, abs_in;

   // ride state
   logic [1:0]  mode_ff, mode_in;
   logic        moving_ff, moving_in;
   logic        tv_ff, tv_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [31:0] last_pulse_ff, last_pulse_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [31:0] rec_ff, rec_in;
   logic [31:0] mov_ff, mov_in;
   logic [rts_pkg::NUM_W-1:0] num_ff, num_in;
   logic [31:0] pulse_acc_ff, pulse_acc_in;
   logic [15:0] peak_ff, peak_in;

   // prepared step terms
   logic [31:0] dt_ff, dt_in;
   logic [31:0] pulses_ff, pulses_in;
   logic [15:0] spd_eff_ff, spd_eff_in;
   logic [rts_pkg::NUM_W-1:0] prod_ff, prod_in;

   // derived results
   logic [31:0] dist_ff, dist_in;
   logic [15:0] avgm_ff, avgm_in;
   logic [15:0] avgr_ff, avgr_in;

   logic [279:0] rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // divider hookup
   logic                       div_start;
   logic [rts_pkg::NUM_W-1:0]  div_dividend;
   logic [rts_pkg::DEN_W-1:0]  div_divisor;
   logic [rts_pkg::NUM_W-1:0]  div_quot;
   rts_pkg::div_stat_type      div_stat;

   rts_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   // helpers
   logic                      csr_wr;
   logic [1:0]                csr_idx;
   logic                      do_upd;
   logic                      riding;
   logic                      paused;
   logic [17:0]               spd_x4;
   logic [17:0]               thr_x3;
   logic                      mov_next;
   logic [rts_pkg::NUM_W-1:0] headroom;
   logic [7:0]                ppr_eff;
   logic [rts_pkg::NUM_W-1:0] dist_x360;
   logic                      out_free;
   logic [31:0]               pause_val;
   logic [31:0]               stop_val;
   logic [31:0]               pulses_new;
   logic                      div_wait;

   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         rts_pkg::REG_THRESHOLD: csr_prdata = {16'd0, thr_ff};
         rts_pkg::REG_CIRC:      csr_prdata = {16'd0, circ_ff};
         rts_pkg::REG_PPR:       csr_prdata = {24'd0, ppr_ff};
         default:                csr_prdata = '0;
      endcase
   end

   assign riding    = (mode_ff == rts_pkg::MODE_RIDING);
   assign paused    = (mode_ff == rts_pkg::MODE_PAUSED);
   assign do_upd    = (func_ff == rts_pkg::FN_UPDATE)
                   || (func_ff == rts_pkg::FN_PAUSE && riding)
                   || (func_ff == rts_pkg::FN_FINISH && (riding || paused));
   assign spd_x4    = {spd_eff_ff, 2'b00};
   assign thr_x3    = {2'b00, thr_ff} + {1'b0, thr_ff, 1'b0};
   // hysteresis: once moving, stay moving down to three quarters of threshold
   assign mov_next  = moving_ff ? (spd_x4 >= thr_x3) : (spd_eff_ff >= thr_ff);
   assign headroom  = rts_pkg::NUM_MAX - num_ff;
   assign ppr_eff   = (ppr_ff == 8'd0) ? 8'd1 : ppr_ff;
   // 360 = 256 + 64 + 32 + 8
   assign dist_x360 = {8'd0, dist_ff, 8'd0} + {10'd0, dist_ff, 6'd0}
                    + {11'd0, dist_ff, 5'd0} + {13'd0, dist_ff, 3'd0};
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pause_val = (elapsed_ff > rec_ff) ? elapsed_ff - rec_ff : 32'd0;
   assign stop_val  = (rec_ff > mov_ff) ? rec_ff - mov_ff : 32'd0;
   // a counter that went backwards adds no pulses
   assign pulses_new = (abs_ff < last_pulse_ff) ? 32'd0 : abs_ff - last_pulse_ff;
   assign div_wait   = state_ff inside {ST_DWAIT, ST_MWAIT, ST_RWAIT};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      thr_in        = thr_ff;
      circ_in       = circ_ff;
      ppr_in        = ppr_ff;
      func_in       = func_ff;
      now_in        = now_ff;
      speed_in      = speed_ff;
      abs_in        = abs_ff;
      mode_in       = mode_ff;
      moving_in     = moving_ff;
      tv_in         = tv_ff;
      last_time_in  = last_time_ff;
      last_pulse_in = last_pulse_ff;
      elapsed_in    = elapsed_ff;
      rec_in        = rec_ff;
      mov_in        = mov_ff;
      num_in        = num_ff;
      pulse_acc_in  = pulse_acc_ff;
      peak_in       = peak_ff;
      dt_in         = dt_ff;
      pulses_in     = pulses_ff;
      spd_eff_in    = spd_eff_ff;
      prod_in       = prod_ff;
      dist_in       = dist_ff;
      avgm_in       = avgm_ff;
      avgr_in       = avgr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      div_start     = 1'b0;
      div_dividend  = num_ff;
      div_divisor   = {24'd0, ppr_eff};

      if (csr_wr) begin
         case (csr_idx)
            rts_pkg::REG_THRESHOLD: thr_in  = csr_pwdata[15:0];
            rts_pkg::REG_CIRC:      circ_in = csr_pwdata[15:0];
            rts_pkg::REG_PPR:       ppr_in  = csr_pwdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               now_in   = req_tdata[31:0];
               speed_in = req_tdata[47:32];
               abs_in   = req_tdata[79:48];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // pause and finish step with zero speed and no new pulses
            dt_in = now_ff - last_time_ff;
            if (func_ff == rts_pkg::FN_UPDATE) begin
               spd_eff_in = speed_ff;
               pulses_in  = pulses_new;
               prod_in    = {16'd0, pulses_new} * {32'd0, circ_ff};
            end else begin
               spd_eff_in = 16'd0;
               pulses_in  = 32'd0;
               prod_in    = '0;
            end
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (do_upd) begin
               if (tv_ff) begin
                  if (riding || paused) elapsed_in = elapsed_ff + dt_ff;
                  if (riding) begin
                     rec_in    = rec_ff + dt_ff;
                     moving_in = mov_next;
                     if (mov_next) mov_in = mov_ff + dt_ff;
                     num_in       = (prod_ff > headroom) ? rts_pkg::NUM_MAX
                                                         : num_ff + prod_ff;
                     pulse_acc_in = pulse_acc_ff + pulses_ff;
                     if (spd_eff_ff > peak_ff) peak_in = spd_eff_ff;
                  end
               end
               tv_in        = 1'b1;
               last_time_in = now_ff;
               if (func_ff == rts_pkg::FN_UPDATE) last_pulse_in = abs_ff;
               if (func_ff == rts_pkg::FN_PAUSE) begin
                  mode_in   = rts_pkg::MODE_PAUSED;
                  moving_in = 1'b0;
               end
               if (func_ff == rts_pkg::FN_FINISH) mode_in = rts_pkg::MODE_FINISHED;
            end
            if (func_ff == rts_pkg::FN_START || func_ff == rts_pkg::FN_NEW) begin
               elapsed_in    = '0;
               rec_in        = '0;
               mov_in        = '0;
               num_in        = '0;
               pulse_acc_in  = '0;
               peak_in       = '0;
               moving_in     = 1'b0;
               mode_in       = (func_ff == rts_pkg::FN_START) ? rts_pkg::MODE_RIDING
                                                             : rts_pkg::MODE_IDLE;
               last_time_in  = now_ff;
               last_pulse_in = abs_ff;
               tv_in         = 1'b1;
            end
            if (func_ff == rts_pkg::FN_RESUME && paused) begin
               mode_in      = rts_pkg::MODE_RIDING;
               last_time_in = now_ff;
               tv_in        = 1'b1;
               moving_in    = 1'b0;
            end
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_stat.done) begin
               dist_in  = (|div_quot[47:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
               state_in = ST_MSTART;
            end
         end
         ST_MSTART: begin
            div_dividend = dist_x360;
            div_divisor  = mov_ff;
            if (mov_ff == 32'd0) begin
               avgm_in  = 16'd0;
               state_in = ST_RSTART;
            end else begin
               div_start = 1'b1;
               state_in  = ST_MWAIT;
            end
         end
         ST_MWAIT: begin
            if (div_stat.done) begin
               avgm_in  = (|div_quot[47:16]) ? 16'hFFFF : div_quot[15:0];
               state_in = ST_RSTART;
            end
         end
         ST_RSTART: begin
            div_dividend = dist_x360;
            div_divisor  = rec_ff;
            if (rec_ff == 32'd0) begin
               avgr_in  = 16'd0;
               state_in = ST_SEND;
            end else begin
               div_start = 1'b1;
               state_in  = ST_RWAIT;
            end
         end
         ST_RWAIT: begin
            if (div_stat.done) begin
               avgr_in  = (|div_quot[47:16]) ? 16'hFFFF : div_quot[15:0];
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_data_in  = {5'd0, avgr_ff, avgm_ff, peak_ff, pulse_acc_ff, dist_ff,
                               stop_val, pause_val, mov_ff, rec_ff, elapsed_ff,
                               moving_ff, mode_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      now_ff      <= now_in;
      speed_ff    <= speed_in;
      abs_ff      <= abs_in;
      dt_ff       <= dt_in;
      pulses_ff   <= pulses_in;
      spd_eff_ff  <= spd_eff_in;
      prod_ff     <= prod_in;
      dist_ff     <= dist_in;
      avgm_ff     <= avgm_in;
      avgr_ff     <= avgr_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         thr_ff        <= rts_pkg::THRESHOLD_RESET;
         circ_ff       <= rts_pkg::CIRC_RESET;
         ppr_ff        <= rts_pkg::PPR_RESET;
         mode_ff       <= rts_pkg::MODE_IDLE;
         moving_ff     <= 1'b0;
         tv_ff         <= 1'b0;
         last_time_ff  <= '0;
         last_pulse_ff <= '0;
         elapsed_ff    <= '0;
         rec_ff        <= '0;
         mov_ff        <= '0;
         num_ff        <= '0;
         pulse_acc_ff  <= '0;
         peak_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thr_ff        <= thr_in;
         circ_ff       <= circ_in;
         ppr_ff        <= ppr_in;
         mode_ff       <= mode_in;
         moving_ff     <= moving_in;
         tv_ff         <= tv_in;
         last_time_ff  <= last_time_in;
         last_pulse_ff <= last_pulse_in;
         elapsed_ff    <= elapsed_in;
         rec_ff        <= rec_in;
         mov_ff        <= mov_in;
         num_ff        <= num_in;
         pulse_acc_ff  <= pulse_acc_in;
         peak_ff       <= peak_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   `RTS_ASSERT_NEXT(a_accept_prep, req_tvalid && req_tready, state_ff == ST_PREP, "no prep")
   `RTS_ASSERT_NOW(a_start_idle_div, div_start, !div_stat.busy, "divider started while busy")
   `RTS_ASSERT_NOW(a_done_in_wait, div_stat.done, div_wait, "divider done outside a wait")
   `RTS_ASSERT_NEXT(a_send_loads, state_ff == ST_SEND && out_free, rsp_tvalid, "result lost")

endmodule

FILE: tb/ride_trip_statistics_top_tb.sv
// Self-checking testbench for the ride trip statistics block
`timescale 1ns / 1ps

module ride_trip_statistics_top_tb;

   typedef struct packed {
      logic [15:0] avg_rec;
      logic [15:0] avg_mov;
      logic [15:0] peak;
      logic [31:0] pulses;
      logic [31:0] dist_mm;
      logic [31:0] stopped;
      logic [31:0] paused;
      logic [31:0] moving;
      logic [31:0] recording;
      logic [31:0] elapsed;
      logic        is_moving;
      logic [1:0]  ride_state;
   } ride_stats_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [279:0] rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   ride_trip_statistics_top DUT (.*);

   // Predictor state: registers and ride accumulators
   logic [15:0] cfg_threshold;
   logic [15:0] cfg_circ;
   logic [7:0]  cfg_ppr;
   logic [1:0]  ride_mode;
   logic        moving_now;
   logic        time_loaded;
   logic [31:0] prev_time;
   logic [31:0] prev_pulses;
   logic [31:0] acc_elapsed;
   logic [31:0] acc_recording;
   logic [31:0] acc_moving;
   logic [47:0] dist_num;
   logic [31:0] acc_pulses;
   logic [15:0] top_speed;

   ride_stats_type stats_due[$];
   int          mismatches;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_cycles;
   logic [31:0] clock_ms;
   logic [31:0] wheel_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit, far above the slowest correct run
   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic void clear_ride();
      acc_elapsed = '0;
      acc_recording = '0;
      acc_moving = '0;
      dist_num = '0;
      acc_pulses = '0;
      top_speed = '0;
      moving_now = 1'b0;
   endfunction

   function automatic void advance_ride(logic [31:0] now, logic [15:0] spd, logic [31:0] cnt);
      logic [31:0] dt;
      logic [31:0] np;
      logic [48:0] sum;
      if (!time_loaded) begin
         prev_time = now;
         prev_pulses = cnt;
         time_loaded = 1'b1;
         return;
      end
      dt = now - prev_time;
      np = (cnt < prev_pulses) ? 32'd0 : cnt - prev_pulses;
      if (ride_mode == rts_pkg::MODE_RIDING || ride_mode == rts_pkg::MODE_PAUSED)
         acc_elapsed += dt;
      if (ride_mode == rts_pkg::MODE_RIDING) begin
         acc_recording += dt;
         if (moving_now)
            moving_now = ({2'b0, spd} * 18'd4) >= ({2'b0, cfg_threshold} * 18'd3);
         else moving_now = spd >= cfg_threshold;
         if (moving_now) acc_moving += dt;
         sum = {1'b0, dist_num} + 49'(np * 48'(cfg_circ));
         dist_num = sum[48] ? rts_pkg::NUM_MAX : sum[47:0];
         acc_pulses += np;
         if (spd > top_speed) top_speed = spd;
      end
      prev_time = now;
      prev_pulses = cnt;
   endfunction

   function automatic logic [15:0] avg_speed(logic [31:0] d, logic [31:0] ms);
      logic [63:0] q;
      if (ms == 0) return 16'd0;
      q = (64'(d) * 64'd360) / 64'(ms);
      return (q > 64'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic ride_stats_type predict_stats(logic [2:0] fn, logic [31:0] now,
                                                    logic [15:0] spd, logic [31:0] cnt);
      ride_stats_type s;
      logic [47:0] d;
      logic [7:0]  ppr;
      case (fn)
         rts_pkg::FN_UPDATE: advance_ride(now, spd, cnt);
         rts_pkg::FN_START, rts_pkg::FN_NEW: begin
            clear_ride();
            ride_mode = (fn == rts_pkg::FN_START) ? rts_pkg::MODE_RIDING
                                                  : rts_pkg::MODE_IDLE;
            prev_time = now;
            prev_pulses = cnt;
            time_loaded = 1'b1;
         end
         rts_pkg::FN_PAUSE: if (ride_mode == rts_pkg::MODE_RIDING) begin
            advance_ride(now, 16'd0, prev_pulses);
            ride_mode = rts_pkg::MODE_PAUSED;
            moving_now = 1'b0;
         end
         rts_pkg::FN_RESUME: if (ride_mode == rts_pkg::MODE_PAUSED) begin
            ride_mode = rts_pkg::MODE_RIDING;
            prev_time = now;
            time_loaded = 1'b1;
            moving_now = 1'b0;
         end
         rts_pkg::FN_FINISH: if (ride_mode == rts_pkg::MODE_RIDING ||
                                 ride_mode == rts_pkg::MODE_PAUSED) begin
            advance_ride(now, 16'd0, prev_pulses);
            ride_mode = rts_pkg::MODE_FINISHED;
         end
         default: ;
      endcase
      ppr = (cfg_ppr == 0) ? 8'd1 : cfg_ppr;
      d = dist_num / ppr;
      s.ride_state = ride_mode;
      s.is_moving = moving_now;
      s.elapsed = acc_elapsed;
      s.recording = acc_recording;
      s.moving = acc_moving;
      s.paused = (acc_elapsed > acc_recording) ? acc_elapsed - acc_recording : 32'd0;
      s.stopped = (acc_recording > acc_moving) ? acc_recording - acc_moving : 32'd0;
      s.dist_mm = (d > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
      s.pulses = acc_pulses;
      s.peak = top_speed;
      s.avg_mov = avg_speed(s.dist_mm, acc_moving);
      s.avg_rec = avg_speed(s.dist_mm, acc_recording);
      return s;
   endfunction

   // Offer one command; hold until the transaction is accepted
   task automatic send_cmd(logic [2:0] fn, logic [31:0] now, logic [15:0] spd,
                           logic [31:0] cnt);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {cnt, spd, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      stats_due.push_back(predict_stats(fn, now, spd, cnt));
   endtask

   // Receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare every result transaction with the oldest prediction
   always @(posedge clock) begin
      ride_stats_type want;
      ride_stats_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[274:0];
         if (stats_due.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
         end else begin
            want = stats_due.pop_front();
            if (got !== want) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) begin
                  $display("ERROR: result mismatch");
                  $display("  expected %h", want);
                  $display("  actual   %h", got);
               end
            end
         end
      end
   end

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (stats_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         rts_pkg::REG_THRESHOLD: cfg_threshold = val[15:0];
         rts_pkg::REG_CIRC:      cfg_circ = val[15:0];
         default:                cfg_ppr = val[7:0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] thr, logic [15:0] circ, logic [7:0] ppr);
      wait_drained();
      write_reg(rts_pkg::REG_THRESHOLD, {16'd0, thr});
      write_reg(rts_pkg::REG_CIRC, {16'd0, circ});
      write_reg(rts_pkg::REG_PPR, {24'd0, ppr});
   endtask

   // Directed: every command, field extremes, backwards pulses, odd codes
   task automatic test_directed();
      send_cmd(rts_pkg::FN_UPDATE, 32'd100, 16'd0, 32'd0);    // first update only loads
      send_cmd(rts_pkg::FN_PAUSE, 32'd150, 16'd0, 32'd0);     // ignored while idle
      send_cmd(rts_pkg::FN_START, 32'd200, 16'd0, 32'd10);
      send_cmd(rts_pkg::FN_UPDATE, 32'd1200, 16'd500, 32'd20);
      send_cmd(rts_pkg::FN_UPDATE, 32'd2200, 16'd230, 32'd30); // hysteresis keeps moving
      send_cmd(rts_pkg::FN_UPDATE, 32'd3200, 16'd224, 32'd35); // drops below 3/4
      send_cmd(rts_pkg::FN_UPDATE, 32'd4200, 16'hFFFF, 32'd5); // counter went back
      send_cmd(rts_pkg::FN_PAUSE, 32'd5200, 16'd100, 32'd90);
      send_cmd(rts_pkg::FN_RESUME, 32'd9000, 16'd0, 32'd90);
      send_cmd(rts_pkg::FN_RESUME, 32'd9100, 16'd0, 32'd90);  // ignored while riding
      send_cmd(rts_pkg::FN_UPDATE, 32'hFFFF_FFF0, 16'd400, 32'hFFFF_FFFF);
      send_cmd(rts_pkg::FN_UPDATE, 32'd50, 16'd400, 32'hFFFF_FFFF); // time wraps
      send_cmd(3'd6, 32'd60, 16'd1, 32'd0);
      send_cmd(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_cmd(rts_pkg::FN_FINISH, 32'd500, 16'd0, 32'd0);
      send_cmd(rts_pkg::FN_FINISH, 32'd600, 16'd0, 32'd0);    // ignored when finished
      send_cmd(rts_pkg::FN_UPDATE, 32'd700, 16'd900, 32'd100);
      send_cmd(rts_pkg::FN_NEW, 32'd800, 16'd0, 32'd7);
      send_cmd(rts_pkg::FN_START, 32'd0, 16'd0, 32'd0);
      // huge distance, then zero dt
      send_cmd(rts_pkg::FN_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_cmd(rts_pkg::FN_UPDATE, 32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF);
      send_cmd(rts_pkg::FN_FINISH, 32'hFFFF_FFFF, 16'd0, 32'd0);
   endtask

   // Mostly well-formed rides with random content, some noise commands
   task automatic test_random(int count);
      logic [2:0]  fn;
      logic [15:0] spd;
      int          r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 4) fn = rts_pkg::FN_START;
         else if (r < 7) fn = rts_pkg::FN_PAUSE;
         else if (r < 10) fn = rts_pkg::FN_RESUME;
         else if (r < 12) fn = rts_pkg::FN_FINISH;
         else if (r < 14) fn = rts_pkg::FN_NEW;
         else if (r < 16) fn = 3'($urandom_range(7));
         else fn = rts_pkg::FN_UPDATE;
         if (ride_mode != rts_pkg::MODE_RIDING && ride_mode != rts_pkg::MODE_PAUSED &&
             $urandom_range(3) != 0)
            fn = rts_pkg::FN_START;
         if ($urandom_range(19) == 0) begin
            clock_ms = $urandom;
            wheel_count = $urandom;
            spd = 16'($urandom);
         end else begin
            clock_ms += $urandom_range(5000);
            if ($urandom_range(29) == 0) wheel_count -= $urandom_range(50);
            else wheel_count += $urandom_range(40);
            spd = 16'($urandom_range(2 * cfg_threshold + 10));
         end
         send_cmd(fn, clock_ms, spd, wheel_count);
      end
   endtask

   // Long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 2000;
      test_random(20);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mismatches = 0;
      hold_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      clock_ms = 0;
      wheel_count = 0;
      cfg_threshold = rts_pkg::THRESHOLD_RESET;
      cfg_circ = rts_pkg::CIRC_RESET;
      cfg_ppr = rts_pkg::PPR_RESET;
      ride_mode = rts_pkg::MODE_IDLE;
      time_loaded = 1'b0;
      prev_time = '0;
      prev_pulses = '0;
      clear_ride();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(150);
      set_config(16'd0, 16'd1, 8'd1);
      send_idle_pct = 51;
      test_random(250);
      set_config(16'hFFFF, 16'hFFFF, 8'hFF);
      send_idle_pct = 0;
      recv_stall_pct = 51;
      test_random(250);
      set_config(16'd1000, 16'd2100, 8'd4);
      send_idle_pct = 37;
      recv_stall_pct = 37;
      test_random(250);
      test_backpressure();
      set_config(16'd300, 16'd2194, 8'd0);
      send_idle_pct = 37;
      recv_stall_pct = 37;
      test_random(200);

      wait_drained();
      if (mismatches == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/rts_pkg.sv
design/rts_divider.sv
design/ride_trip_statistics_top.sv
tb/ride_trip_statistics_top_tb.sv
